FILE: hdl/field_radix_decomposer_macros.svh
// Assertion macros shared by the decomposer RTL.
`ifndef FIELD_RADIX_DECOMPOSER_MACROS_SVH
`define FIELD_RADIX_DECOMPOSER_MACROS_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define FRD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frd assertion failed");
// Check cons in the cycle after ante holds.
`define FRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frd assertion failed");
`else
`define FRD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define FRD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/frd_pkg.sv
// Shared constants, types and command/status bundles of the radix decomposer.
package frd_pkg;
   localparam int MAX_LIMBS         = 256;
   localparam int DIGITS_PER_RESULT = 8;
   localparam int LIMB_IW           = $clog2(MAX_LIMBS);
   localparam int LIMB_CW           = $clog2(MAX_LIMBS + 1);
   localparam int SLOT_W            = $clog2(DIGITS_PER_RESULT);
   localparam int VAL_W             = 256;
   localparam int REQ_DATA_W        = 320;
   localparam int RSP_DATA_W        = 104;
   localparam logic [32:0] MEMORY_SIZE = 33'h1_0000_0000;
   localparam logic [15:0] RADIX_MIN   = 16'd2;
   localparam logic [15:0] RADIX_MAX   = 16'd256;
   localparam logic [15:0] RADIX_BITS  = 16'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_PARAM = 2'd1;
   localparam logic [1:0] STATUS_TRUNC = 2'd2;

   typedef enum logic [1:0] {
      EMIT_PARAM,
      EMIT_TRUNC,
      EMIT_EMPTY,
      EMIT_GROUP
   } emit_kind_type;

   typedef struct packed {
      logic          load;
      logic          div_init;
      logic          div_step;
      logic          grp_init;
      logic          grp_next;
      logic          rd_issue;
      logic          rd_capture;
      logic          emit;
      emit_kind_type kind;
   } frd_cmd_type;

   typedef struct packed {
      logic param_bad;
      logic val_zero;
      logic trunc;
      logic limbs_zero;
      logic div_last;
      logic slot_last;
      logic grp_final;
      logic out_free;
   } frd_sts_type;
endpackage

FILE: hdl/frd_datapath.sv
// Datapath: operand registers, byte-wide short divider, digit memory, result register.
module frd_datapath import frd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  frd_cmd_type           cmd,
   output frd_sts_type           sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   logic [VAL_W-1:0]   val_ff;
   logic [15:0]        radix_ff;
   logic [15:0]        limbs_ff;
   logic               bits_ff;
   logic [31:0]        dest_ff;
   logic [4:0]         step_ff;
   logic [7:0]         rem_ff;
   logic [LIMB_CW-1:0] n_ff;
   logic [LIMB_CW-1:0] grp_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [63:0]        bytes_ff;
   logic [7:0]         rd_data_ff;
   logic               pos_ok_ff;
   logic [7:0]         mem [MAX_LIMBS];

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [31:0]        rsp_addr_ff;
   logic [63:0]        rsp_bytes_ff;
   logic [3:0]         rsp_count_ff;
   logic               rsp_tag_ff;
   logic               rsp_last_ff;

   logic [7:0]  quot_in;
   logic [7:0]  rem_in;
   logic [32:0] span;
   logic [15:0] pos;
   logic [15:0] grp_slot;

   // Eight restoring-division steps on the top byte of the value.
   always_comb begin
      logic [8:0] r;
      r = {1'b0, rem_ff};
      quot_in = '0;
      for (int k = 0; k < 8; k++) begin
         r = {r[7:0], val_ff[VAL_W-1-k]};
         if (r >= radix_ff[8:0]) begin
            r = r - radix_ff[8:0];
            quot_in[7-k] = 1'b1;
         end
      end
      rem_in = r[7:0];
   end

   assign span     = {1'b0, dest_ff} + {17'd0, limbs_ff};
   assign grp_slot = 16'(grp_ff) + 16'(slot_ff);
   assign pos      = limbs_ff - 16'd1 - grp_slot;

   always_comb begin
      sts.val_zero   = ~|val_ff;
      sts.param_bad  = (span > MEMORY_SIZE) || (radix_ff < RADIX_MIN) ||
                       (radix_ff > RADIX_MAX) || (bits_ff && radix_ff != RADIX_BITS) ||
                       (limbs_ff == 16'd0 && !sts.val_zero) ||
                       (limbs_ff > 16'(MAX_LIMBS));
      sts.trunc      = 16'(n_ff) == limbs_ff;
      sts.limbs_zero = limbs_ff == 16'd0;
      sts.div_last   = &step_ff;
      sts.slot_last  = (slot_ff == SLOT_W'(DIGITS_PER_RESULT - 1)) ||
                       (grp_slot + 16'd1 >= limbs_ff);
      sts.grp_final  = 16'(grp_ff) + 16'(DIGITS_PER_RESULT) >= limbs_ff;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   // Digit memory: written once per digit, read one slot at a time.
   always_ff @(posedge clock) begin
      if (cmd.div_step && (&step_ff)) begin
         mem[n_ff[LIMB_IW-1:0]] <= rem_in;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[pos[LIMB_IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         step_ff      <= '0;
         grp_ff       <= '0;
         slot_ff      <= '0;
      end else begin
         if (cmd.load) begin
            val_ff   <= {2'b00, req_tdata[253:0]};
            radix_ff <= req_tdata[269:254];
            limbs_ff <= req_tdata[285:270];
            dest_ff  <= req_tdata[317:286];
            bits_ff  <= req_tuser;
            n_ff     <= '0;
         end
         if (cmd.div_init) begin
            step_ff <= '0;
            rem_ff  <= '0;
         end
         if (cmd.div_step) begin
            val_ff  <= {val_ff[VAL_W-9:0], quot_in};
            rem_ff  <= rem_in;
            step_ff <= step_ff + 5'd1;
            if (&step_ff) begin
               n_ff <= n_ff + LIMB_CW'(1);
            end
         end
         if (cmd.rd_issue) begin
            pos_ok_ff <= pos < 16'(n_ff);
         end
         if (cmd.rd_capture) begin
            bytes_ff[8*slot_ff +: 8] <= pos_ok_ff ? rd_data_ff : 8'd0;
            if (!sts.slot_last) begin
               slot_ff <= slot_ff + SLOT_W'(1);
            end
         end
         if (cmd.grp_init) begin
            grp_ff   <= '0;
            slot_ff  <= '0;
            bytes_ff <= '0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            case (cmd.kind)
               EMIT_PARAM: begin
                  rsp_status_ff <= STATUS_PARAM;
                  rsp_addr_ff   <= '0;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_tag_ff    <= 1'b0;
                  rsp_last_ff   <= 1'b1;
               end
               EMIT_TRUNC: begin
                  rsp_status_ff <= STATUS_TRUNC;
                  rsp_addr_ff   <= '0;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_tag_ff    <= 1'b0;
                  rsp_last_ff   <= 1'b1;
               end
               EMIT_EMPTY: begin
                  rsp_status_ff <= STATUS_OK;
                  rsp_addr_ff   <= dest_ff;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_tag_ff    <= bits_ff;
                  rsp_last_ff   <= 1'b1;
               end
               EMIT_GROUP: begin
                  rsp_status_ff <= STATUS_OK;
                  rsp_addr_ff   <= dest_ff + 32'(grp_ff);
                  rsp_bytes_ff  <= bytes_ff;
                  rsp_count_ff  <= 4'(slot_ff) + 4'd1;
                  rsp_tag_ff    <= bits_ff;
                  rsp_last_ff   <= sts.grp_final;
               end
               default: begin
                  rsp_status_ff <= STATUS_PARAM;
                  rsp_addr_ff   <= '0;
                  rsp_bytes_ff  <= '0;
                  rsp_count_ff  <= '0;
                  rsp_tag_ff    <= 1'b0;
                  rsp_last_ff   <= 1'b1;
               end
            endcase
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.grp_next) begin
            grp_ff   <= grp_ff + LIMB_CW'(DIGITS_PER_RESULT);
            slot_ff  <= '0;
            bytes_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_bytes_ff, rsp_addr_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_tag_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule

FILE: hdl/frd_control.sv
// Controller: sequences checks, digit divisions, group reads and result emission.
module frd_control import frd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  frd_sts_type sts,
   output frd_cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIGIT,
      S_DIVIDE,
      S_POST,
      S_READ,
      S_CAPTURE,
      S_EMIT
   } state_type;

   state_type     state_ff, state_in;
   emit_kind_type kind_ff, kind_in;

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      cmd        = '0;
      cmd.kind   = kind_ff;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.param_bad) begin
               kind_in  = EMIT_PARAM;
               state_in = S_EMIT;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            if (sts.val_zero) begin
               state_in = S_POST;
            end else if (sts.trunc) begin
               kind_in  = EMIT_TRUNC;
               state_in = S_EMIT;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DIGIT;
            end
         end
         S_POST: begin
            if (sts.limbs_zero) begin
               kind_in  = EMIT_EMPTY;
               state_in = S_EMIT;
            end else begin
               cmd.grp_init = 1'b1;
               kind_in      = EMIT_GROUP;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_CAPTURE;
         end
         S_CAPTURE: begin
            cmd.rd_capture = 1'b1;
            state_in       = sts.slot_last ? S_EMIT : S_READ;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (kind_ff == EMIT_GROUP && !sts.grp_final) begin
                  cmd.grp_next = 1'b1;
                  state_in     = S_READ;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= EMIT_PARAM;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end
endmodule

FILE: hdl/field_radix_decomposer.sv
// Each item runs through the checks, then one digit at a time (32 byte steps of the short
// divider plus one zero test), then one read and capture per digit slot plus one emit
// per group. One item is worked at a time, and the divider's byte-per-cycle loop takes
// most of its time. A new item may enter while the last result beat still waits.
// Synchronous reset clears control only; the digit memory holds no reset and is read
// only where written for the current item.
`include "field_radix_decomposer_macros.svh"
module field_radix_decomposer import frd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tdata: value_word0, value_word1, value_word2, value_word3, radix,
   //            limb_total, dest_address, two zero bits
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: bit_output
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: status, group_address, digit_bytes, digit_count, two zero bits
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: bits_tag
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);
   frd_cmd_type cmd;
   frd_sts_type sts;
   logic        rsp_err;
   logic [3:0]  rsp_count;

   // Controller steps the item; datapath holds operands, divider and digit store.
   frd_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   frd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Pick the status and digit count out of the result beat for the checks.
   assign rsp_err   = rsp_tvalid && rsp_tdata[1:0] != STATUS_OK;
   assign rsp_count = rsp_tdata[101:98];

   // An accepted beat moves the controller out of idle at once.
   `FRD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // Error beats are final and carry no digits.
   `FRD_ASSERT_SAME(a_error_final, clock, reset, rsp_err, rsp_tlast && rsp_count == 4'd0)
   // A group never claims more than eight digits.
   `FRD_ASSERT_SAME(a_count_range, clock, reset, rsp_tvalid, rsp_count <= 4'd8)
   // Emission only happens when the result register can take it.
   `FRD_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, sts.out_free)
endmodule

FILE: dv/testbench.sv
// Self-checking bench for the radix decomposer: directed and randomized beats checked against a digit predictor.
`timescale 1ns / 1ps
module testbench;
   import frd_pkg::*;

   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int DRAIN_CYCLES = 12_000;  // long enough for one worst-case item of 254 digits

   // One request, unpacked into its fields.
   typedef struct {
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [61:0] word3;
      logic [15:0] radix;
      logic [15:0] limbs;
      logic        bit_out;
      logic [31:0] dest;
      bit          wait_idle;  // hold this beat until every digit group has arrived
   } decomp_req_t;

   // One result beat.
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] addr;
      logic [63:0] digits;
      logic [3:0]  count;
      logic        tag;
      logic        last;
   } digit_group_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // req_tdata: value_word0, value_word1, value_word2, value_word3, radix,
   //            limb_total, dest_address, two zero bits
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // req_tuser: bit_output
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // rsp_tdata: status, group_address, digit_bytes, digit_count, two zero bits
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // rsp_tuser: bits_tag
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   decomp_req_t  pending_reqs[$];
   digit_group_t expected_groups[$];
   decomp_req_t  on_bus;
   int           offered = 0;
   int           accepted = 0;
   int           mismatches = 0;
   int           cycles = 0;
   bit           rx_hold = 1'b0;

   field_radix_decomposer DUT (.*);

   always #5 clock = ~clock;

   // Work out every digit group one request produces, in output order.
   task automatic predict_digit_groups(input decomp_req_t r);
      logic [255:0] val;
      logic [255:0] base;
      logic [7:0]   le_dig[0:511];
      logic [32:0]  span;
      digit_group_t g;
      int           n;
      int           j;
      bit           bad;
      val  = {2'b00, r.word3, r.word2, r.word1, r.word0};
      base = {240'd0, r.radix};
      span = {1'b0, r.dest} + {17'd0, r.limbs};
      bad  = span > MEMORY_SIZE || r.radix < RADIX_MIN || r.radix > RADIX_MAX
             || (r.bit_out && r.radix != RADIX_BITS) || (r.limbs == 0 && val != 0)
             || r.limbs > MAX_LIMBS;
      g = '{STATUS_PARAM, 32'd0, 64'd0, 4'd0, 1'b0, 1'b1};
      if (bad) begin
         expected_groups.insert(expected_groups.size(), g);
         return;
      end
      for (int k = 0; k < 512; k++) le_dig[k] = 8'd0;
      n = 0;
      while (val != 0 && n < 512) begin
         le_dig[n] = 8'(val % base);
         val = val / base;
         n++;
      end
      if (n > r.limbs) begin
         g.status = STATUS_TRUNC;
         expected_groups.insert(expected_groups.size(), g);
         return;
      end
      if (r.limbs == 0) begin
         g = '{STATUS_OK, r.dest, 64'd0, 4'd0, r.bit_out, 1'b1};
         expected_groups.insert(expected_groups.size(), g);
         return;
      end
      for (int i = 0; i < r.limbs; i += DIGITS_PER_RESULT) begin
         g = '{STATUS_OK, r.dest + 32'(i), 64'd0, 4'd0, r.bit_out, 1'b0};
         for (j = 0; j < DIGITS_PER_RESULT && i + j < r.limbs; j++)
            g.digits[8*j +: 8] = le_dig[r.limbs - 1 - (i + j)];
         g.count = 4'(j);
         g.last  = (i + DIGITS_PER_RESULT >= r.limbs);
         expected_groups.insert(expected_groups.size(), g);
      end
   endtask

   // Build a value that fits in roughly ndig digits of the given radix.
   function automatic decomp_req_t from_digits(input logic [15:0] radix, input int ndig,
                                               input logic [15:0] limbs, input logic bo,
                                               input logic [31:0] dest);
      decomp_req_t  r;
      logic [255:0] v;
      v = '0;
      for (int i = 0; i < ndig; i++)
         v = v * radix + $urandom_range(radix - 1, (i == 0 && ndig > 0) ? 1 : 0);
      r = '{v[63:0], v[127:64], v[191:128], v[253:192], radix, limbs, bo, dest, 1'b0};
      return r;
   endfunction

   function automatic decomp_req_t noise_req();
      decomp_req_t r;
      r.word0 = {$urandom, $urandom};
      r.word1 = {$urandom, $urandom};
      r.word2 = {$urandom, $urandom};
      r.word3 = 62'({$urandom, $urandom});
      r.radix = ($urandom_range(1, 0)) ? 16'($urandom) : 16'($urandom_range(300));
      r.limbs = ($urandom_range(1, 0)) ? 16'($urandom) : 16'($urandom_range(300));
      r.bit_out = 1'($urandom);
      r.dest = $urandom;
      r.wait_idle = 1'b0;
      return r;
   endfunction

   // Idle mix follows the accepted count: none, sender 85, receiver 85, both 32.
   function automatic int idle_pct(input bit rx_side);
      case ((accepted / 30) % 5)
         1: return rx_side ? 0 : 85;
         2: return rx_side ? 85 : 0;
         3: return 32;
         default: return 0;
      endcase
   endfunction

   // Driver: advance to the next beat once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rx_hold && ($urandom_range(99) >= idle_pct(1));
         if (!(req_tvalid && accepted != offered)) begin
            if (pending_reqs.size() != 0
                && !(pending_reqs[0].wait_idle && expected_groups.size() != 0)
                && $urandom_range(99) >= idle_pct(0)) begin
               on_bus = pending_reqs.pop_front();
               req_tdata <= {2'b00, on_bus.dest, on_bus.limbs, on_bus.radix, on_bus.word3,
                             on_bus.word2, on_bus.word1, on_bus.word0};
               req_tuser <= on_bus.bit_out;
               req_tvalid <= 1'b1;
               offered++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on each accepted request, check each result beat.
   always @(posedge clock) begin
      digit_group_t got;
      digit_group_t want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_digit_groups(on_bus);
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[97:34], rsp_tdata[101:98],
                    rsp_tuser, rsp_tlast};
            if (expected_groups.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat: %p", got);
            end else begin
               want = expected_groups.pop_front();
               if (got !== want || rsp_tdata[103:102] !== 2'b00) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input.
   initial begin
      wait (accepted >= 45);
      rx_hold = 1'b1;
      repeat (4000) @(posedge clock);
      rx_hold = 1'b0;
   end

   initial begin
      decomp_req_t r;
      int          nd;
      logic [15:0] rad;
      logic [15:0] lim;
      // Directed: bad radix, bit mode rules, empty, limb and address edges, truncation.
      r = from_digits(16'd10, 3, 16'd4, 1'b0, 32'd100);
      r.radix = 16'd0;   pending_reqs.insert(pending_reqs.size(), r);
      r.radix = 16'd1;   pending_reqs.insert(pending_reqs.size(), r);
      r.radix = 16'd257; pending_reqs.insert(pending_reqs.size(), r);
      r.radix = 16'hFFFF; pending_reqs.insert(pending_reqs.size(), r);
      pending_reqs.insert(pending_reqs.size(), from_digits(16'd3, 2, 16'd4, 1'b1, 32'd0));
      pending_reqs.insert(pending_reqs.size(), from_digits(16'd2, 5, 16'd8, 1'b1, 32'd7));
      pending_reqs.insert(pending_reqs.size(), from_digits(16'd16, 0, 16'd0, 1'b0, 32'd55));
      pending_reqs.insert(pending_reqs.size(),
                          from_digits(16'd2, 0, 16'd0, 1'b1, 32'hFFFF_FFFF));
      pending_reqs.insert(pending_reqs.size(), from_digits(16'd16, 2, 16'd0, 1'b0, 32'd55));
      pending_reqs.insert(pending_reqs.size(), from_digits(16'd16, 2, 16'd257, 1'b0, 32'd0));
      pending_reqs.insert(pending_reqs.size(),
                          from_digits(16'd16, 2, 16'hFFFF, 1'b0, 32'd0));
      pending_reqs.insert(pending_reqs.size(),
                          from_digits(16'd256, 1, 16'd1, 1'b0, 32'hFFFF_FFFF));
      pending_reqs.insert(pending_reqs.size(),
                          from_digits(16'd256, 1, 16'd2, 1'b0, 32'hFFFF_FFFF));
      pending_reqs.insert(pending_reqs.size(), from_digits(16'd7, 9, 16'd8, 1'b0, 32'd12));
      r = '{'1, '1, '1, '1, 16'd256, 16'd32, 1'b0, 32'h8000_0000, 1'b0};
      pending_reqs.insert(pending_reqs.size(), r);
      r.radix = 16'd2; r.limbs = 16'd254; r.bit_out = 1'b1;
      pending_reqs.insert(pending_reqs.size(), r);
      r.limbs = 16'd253; pending_reqs.insert(pending_reqs.size(), r);
      r.radix = 16'd256; r.limbs = 16'd256; r.bit_out = 1'b0; r.dest = 32'd0;
      pending_reqs.insert(pending_reqs.size(), r);
      pending_reqs.insert(pending_reqs.size(),
                          from_digits(16'd255, 13, 16'd13, 1'b0, 32'd3));
      // Random: mostly well-formed requests, some truncating, rest noise.
      for (int i = 0; i < 121; i++) begin
         if ($urandom_range(99) < 20) begin
            r = noise_req();
         end else begin
            rad = ($urandom_range(3) == 0) ? 16'd2 : 16'($urandom_range(256, 2));
            lim = ($urandom_range(15) == 0) ? 16'($urandom_range(256, 1))
                                            : 16'($urandom_range(24, 1));
            nd = ($urandom_range(9) == 0) ? lim + 1 : $urandom_range(lim);
            if (nd > 40) nd = 40;
            r = from_digits(rad, nd, lim, (rad == 2) ? 1'($urandom) : 1'b0, $urandom);
            if (r.dest > 32'hFFFF_FF00 && $urandom_range(1)) r.dest = 32'hFFFF_FFFF - lim;
         end
         // Pause the sender until the block has fully drained.
         r.wait_idle = (i % 37 == 20);
         pending_reqs.insert(pending_reqs.size(), r);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0 && accepted == offered);
      wait (expected_groups.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_groups.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
